[src/pspr_pkg.sv]
// ----------------------------------------------------------------------------
// PCM sample player package
// Shared widths, codes, reset values and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pspr_pkg;

    // Field widths
    localparam int CNT_W     = 13;
    localparam int SPM_W     = 10;
    localparam int MODE_W    = 2;
    localparam int MS_W      = 16;
    localparam int RND_W     = 15;
    localparam int ADDR_W    = 12;
    localparam int SMP_W     = 8;
    localparam int ACT_W     = 2;
    localparam int PROD_W    = MS_W + SPM_W;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // Shared divider: one quotient bit per cycle
    localparam int DIV_W     = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Register port
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    localparam logic [2:0] REG_SAMPLE_COUNT   = 3'd0;
    localparam logic [2:0] REG_MS_SAMPLES     = 3'd1;
    localparam logic [2:0] REG_PLAY_MODE      = 3'd2;
    localparam logic [2:0] REG_PLAY_TIME_MS   = 3'd3;
    localparam logic [2:0] REG_MIX_PERIOD_MS  = 3'd4;

    // Register reset values
    localparam logic [CNT_W-1:0]  RST_SAMPLE_COUNT   = 13'd4096;
    localparam logic [SPM_W-1:0]  RST_MS_SAMPLES     = 10'd40;
    localparam logic [MODE_W-1:0] RST_PLAY_MODE      = 2'd0;
    localparam logic [MS_W-1:0]   RST_PLAY_TIME_MS   = 16'd1000;
    localparam logic [MS_W-1:0]   RST_MIX_PERIOD_MS  = 16'd0;

    // Item kinds
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START = 2'd1;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd2;

    // Play modes
    localparam logic [MODE_W-1:0] MODE_ONCE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd2;

    localparam logic [SMP_W-1:0] IDLE_DUTY = 8'd127;

    typedef struct packed {
        logic [CNT_W-1:0]  sample_count;
        logic [SPM_W-1:0]  ms_samples;
        logic [MODE_W-1:0] play_mode;
        logic [MS_W-1:0]   play_time_ms;
        logic [MS_W-1:0]   mix_period_ms;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic mem_write;
        logic tick_begin;
        logic clip_div;
        logic start_apply;
        logic dec_ms;
        logic mix_div;
        logic jump_div;
        logic jump_mul;
        logic jump_add;
        logic tick_end;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             enabled;
        logic             mode_valid;
        logic             div_busy;
        logic             rem_zero;
        logic             ms_zero;
        logic             period_zero;
        logic             out_free;
    } sts_t;

endpackage

[src/pspr_regs.sv]
// ----------------------------------------------------------------------------
// PCM sample player register bank
// Five configuration registers behind an APB-style port, read back as written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pspr_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pspr_pkg::PADDR_W-1:0]   paddr,
    input  logic [pspr_pkg::PDATA_W-1:0]   pwdata,
    output logic [pspr_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output pspr_pkg::cfg_t                 cfg
);
    import pspr_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_count   <= RST_SAMPLE_COUNT;
            cfg_reg.ms_samples     <= RST_MS_SAMPLES;
            cfg_reg.play_mode      <= RST_PLAY_MODE;
            cfg_reg.play_time_ms   <= RST_PLAY_TIME_MS;
            cfg_reg.mix_period_ms  <= RST_MIX_PERIOD_MS;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SAMPLE_COUNT:   cfg_reg.sample_count   <= pwdata[CNT_W-1:0];
                REG_MS_SAMPLES:     cfg_reg.ms_samples     <= pwdata[SPM_W-1:0];
                REG_PLAY_MODE:      cfg_reg.play_mode      <= pwdata[MODE_W-1:0];
                REG_PLAY_TIME_MS:   cfg_reg.play_time_ms   <= pwdata[MS_W-1:0];
                REG_MIX_PERIOD_MS:  cfg_reg.mix_period_ms  <= pwdata[MS_W-1:0];
                default:            ;
            endcase
        end
    end

    // Read-back
    always_comb
    begin
        unique case (reg_idx)
            REG_SAMPLE_COUNT:   prdata = PDATA_W'(cfg_reg.sample_count);
            REG_MS_SAMPLES:     prdata = PDATA_W'(cfg_reg.ms_samples);
            REG_PLAY_MODE:      prdata = PDATA_W'(cfg_reg.play_mode);
            REG_PLAY_TIME_MS:   prdata = PDATA_W'(cfg_reg.play_time_ms);
            REG_MIX_PERIOD_MS:  prdata = PDATA_W'(cfg_reg.mix_period_ms);
            default:            prdata = '0;
        endcase
    end

endmodule

[src/pspr_div.sv]
// ----------------------------------------------------------------------------
// PCM sample player divider
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pspr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pspr_pkg::DIV_W-1:0]  dividend,
    input  logic [pspr_pkg::DIV_W-1:0]  divisor,
    output logic                        busy,
    output logic [pspr_pkg::DIV_W-1:0]  quotient,
    output logic [pspr_pkg::DIV_W-1:0]  remainder
);
    import pspr_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     r_reg, r_next;
    logic [DIV_W-1:0]     q_reg, q_next;
    logic [DIV_W-1:0]     d_reg;
    logic [DIV_W:0]       trial;
    logic                 fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial  = {r_reg, q_reg[DIV_W-1]};
        fits   = (trial >= {1'b0, d_reg});
        r_next = fits ? DIV_W'(trial - {1'b0, d_reg}) : trial[DIV_W-1:0];
        q_next = {q_reg[DIV_W-2:0], fits};
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Operand and partial remainder registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= '0;
            q_reg <= dividend;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            q_reg <= q_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

[src/pspr_datapath.sv]
// ----------------------------------------------------------------------------
// PCM sample player datapath
// Sample store, playback state, divider, jump multiplier and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pspr_datapath #(
    parameter int SAMPLE_DEPTH = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pspr_pkg::cfg_t                  cfg,
    input  pspr_pkg::cmd_t                  cmd,
    output pspr_pkg::sts_t                  sts,
    input  logic [pspr_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [pspr_pkg::ACT_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pspr_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import pspr_pkg::*;

    localparam int          IW      = $clog2(SAMPLE_DEPTH);
    localparam int          SUM_W   = PROD_W + 1;
    localparam logic [16:0] DEPTH_W = 17'(SAMPLE_DEPTH);

    // Latched item
    logic [ACT_W-1:0]  act_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SMP_W-1:0]  val_reg;
    logic [RND_W-1:0]  rnd_reg;

    // Playback state
    logic [IW-1:0]     read_index_reg;
    logic [MS_W-1:0]   remaining_reg;
    logic [MS_W-1:0]   period_reg;
    logic              enabled_reg;
    logic [SMP_W-1:0]  duty_reg;
    logic              fin_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SMP_W-1:0]  rd_data_reg;
    logic              m_tvalid_reg;

    logic [SMP_W-1:0]  sample_store_mem [SAMPLE_DEPTH];

    logic [CNT_W-1:0]  cnt_eff;
    logic [SPM_W-1:0]  spm_eff;
    logic [IW:0]       idx_inc;
    logic [IW-1:0]     idx_wrap;
    logic [SUM_W-1:0]  jump_sum;
    logic [IW-1:0]     jump_idx;
    logic              mem_we;
    logic [IW-1:0]     wr_addr;

    logic              div_start;
    logic [DIV_W-1:0]  div_dividend, div_divisor;
    logic              div_busy;
    logic [DIV_W-1:0]  div_quot, div_rem;

    logic [MS_W-1:0]   clip_ms;
    logic [MS_W-1:0]   start_time;
    logic [MS_W-1:0]   start_period;

    // Effective clip length and rate
    always_comb
    begin
        if (cfg.sample_count == '0)
        begin
            cnt_eff = CNT_W'(1);
        end
        else if (17'(cfg.sample_count) > DEPTH_W)
        begin
            cnt_eff = DEPTH_W[CNT_W-1:0];
        end
        else
        begin
            cnt_eff = cfg.sample_count;
        end
        spm_eff = (cfg.ms_samples == '0) ? SPM_W'(1) : cfg.ms_samples;
    end

    // Index advance and jump, both wrapped to zero at the clip end
    always_comb
    begin
        idx_inc  = {1'b0, read_index_reg} + 1'b1;
        idx_wrap = (SUM_W'(idx_inc) >= SUM_W'(cnt_eff)) ? '0 : idx_inc[IW-1:0];
        jump_sum = SUM_W'(read_index_reg) + SUM_W'(prod_reg);
        jump_idx = (jump_sum >= SUM_W'(cnt_eff)) ? '0 : jump_sum[IW-1:0];
    end

    // Start settings
    always_comb
    begin
        clip_ms      = div_quot;
        start_time   = (cfg.play_mode == MODE_ONCE) ? clip_ms : cfg.play_time_ms;
        start_period = '0;
        if (cfg.play_mode == MODE_RANDOM)
        begin
            start_period = (cfg.mix_period_ms >= clip_ms) ? clip_ms : cfg.mix_period_ms;
        end
    end

    // Divider operand selection
    always_comb
    begin
        div_start = cmd.tick_begin | cmd.clip_div | cmd.mix_div | cmd.jump_div;
        priority if (cmd.tick_begin)
        begin
            div_dividend = DIV_W'(read_index_reg);
            div_divisor  = DIV_W'(spm_eff);
        end
        else if (cmd.clip_div)
        begin
            div_dividend = DIV_W'(cnt_eff);
            div_divisor  = DIV_W'(spm_eff);
        end
        else if (cmd.mix_div)
        begin
            div_dividend = remaining_reg;
            div_divisor  = period_reg;
        end
        else
        begin
            div_dividend = DIV_W'(rnd_reg);
            div_divisor  = period_reg;
        end
    end

    pspr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Sample store: one write port, one registered read port
    assign mem_we  = cmd.mem_write && (17'(addr_reg) < DEPTH_W);
    assign wr_addr = IW'(addr_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_store_mem[wr_addr] <= val_reg;
        end
        if (cmd.tick_begin)
        begin
            rd_data_reg <= sample_store_mem[read_index_reg];
        end
    end

    // Item capture and jump product
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            act_reg  <= s_tuser;
            addr_reg <= s_tdata[11:0];
            val_reg  <= s_tdata[19:12];
            rnd_reg  <= s_tdata[34:20];
        end
        if (cmd.jump_mul)
        begin
            prod_reg <= div_rem * spm_eff;
        end
    end

    // Playback state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_index_reg <= '0;
            remaining_reg  <= '0;
            period_reg     <= '0;
            enabled_reg    <= 1'b0;
            duty_reg       <= IDLE_DUTY;
            fin_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                fin_reg <= 1'b0;
            end
            if (cmd.tick_begin)
            begin
                read_index_reg <= idx_wrap;
            end
            if (cmd.start_apply && (start_time != '0))
            begin
                remaining_reg  <= start_time;
                read_index_reg <= '0;
                period_reg     <= start_period;
                enabled_reg    <= 1'b1;
            end
            if (cmd.dec_ms)
            begin
                remaining_reg <= remaining_reg - 1'b1;
            end
            if (cmd.jump_add)
            begin
                read_index_reg <= jump_idx;
            end
            if (cmd.tick_end)
            begin
                if (remaining_reg == '0)
                begin
                    enabled_reg    <= 1'b0;
                    read_index_reg <= '0;
                    duty_reg       <= IDLE_DUTY;
                    fin_reg        <= 1'b1;
                end
                else
                begin
                    duty_reg <= rd_data_reg;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata <= duty_reg;
            m_tuser <= enabled_reg;
            m_tlast <= fin_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // Status back to the controller
    always_comb
    begin
        sts.action      = act_reg;
        sts.enabled     = enabled_reg;
        sts.mode_valid  = (cfg.play_mode == MODE_ONCE) || (cfg.play_mode == MODE_LOOP)
                          || (cfg.play_mode == MODE_RANDOM);
        sts.div_busy    = div_busy;
        sts.rem_zero    = (div_rem == '0);
        sts.ms_zero     = (remaining_reg == '0);
        sts.period_zero = (period_reg == '0);
        sts.out_free    = !m_tvalid_reg || m_tready;
    end

endmodule

[src/pspr_ctrl.sv]
// ----------------------------------------------------------------------------
// PCM sample player controller
// Sequences one item at a time through the datapath: dispatch, divisions,
// jump, tick completion and hand-off to the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pspr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  pspr_pkg::sts_t  sts,
    output pspr_pkg::cmd_t  cmd
);
    import pspr_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_DISPATCH = 10'b00_0000_0010,
        ST_CLIP     = 10'b00_0000_0100,
        ST_PHASE    = 10'b00_0000_1000,
        ST_DEC      = 10'b00_0001_0000,
        ST_MIX      = 10'b00_0010_0000,
        ST_JUMP     = 10'b00_0100_0000,
        ST_ADD      = 10'b00_1000_0000,
        ST_TICK_END = 10'b01_0000_0000,
        ST_RESULT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                priority if (sts.action == ACT_WRITE)
                begin
                    cmd.mem_write = 1'b1;
                    state_next    = ST_RESULT;
                end
                else if (sts.action == ACT_START && sts.mode_valid)
                begin
                    cmd.clip_div = 1'b1;
                    state_next   = ST_CLIP;
                end
                else if (sts.action == ACT_TICK && sts.enabled)
                begin
                    cmd.tick_begin = 1'b1;
                    state_next     = ST_PHASE;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_CLIP:
            begin
                if (!sts.div_busy)
                begin
                    cmd.start_apply = 1'b1;
                    state_next      = ST_RESULT;
                end
            end
            // Millisecond boundary when the index is a multiple of the rate
            ST_PHASE:
            begin
                if (!sts.div_busy)
                begin
                    if (sts.rem_zero)
                    begin
                        cmd.dec_ms = 1'b1;
                        state_next = ST_DEC;
                    end
                    else
                    begin
                        state_next = ST_TICK_END;
                    end
                end
            end
            // No jump when playback ends here anyway or jumps are off
            ST_DEC:
            begin
                if (sts.ms_zero || sts.period_zero)
                begin
                    state_next = ST_TICK_END;
                end
                else
                begin
                    cmd.mix_div = 1'b1;
                    state_next  = ST_MIX;
                end
            end
            ST_MIX:
            begin
                if (!sts.div_busy)
                begin
                    if (sts.rem_zero)
                    begin
                        cmd.jump_div = 1'b1;
                        state_next   = ST_JUMP;
                    end
                    else
                    begin
                        state_next = ST_TICK_END;
                    end
                end
            end
            ST_JUMP:
            begin
                if (!sts.div_busy)
                begin
                    cmd.jump_mul = 1'b1;
                    state_next   = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.jump_add = 1'b1;
                state_next   = ST_TICK_END;
            end
            ST_TICK_END:
            begin
                cmd.tick_end = 1'b1;
                state_next   = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/pcm_sample_player_with_random_jump.sv]
// ----------------------------------------------------------------------------
// PCM sample player with random jump
// Input stream: one item per transfer; s_tuser is the kind (tick, start,
// sample write), s_tdata carries the write address, the sample byte and a
// random number. Every item yields one result transfer on the output stream:
// m_tdata the PWM duty, m_tuser the playing flag, m_tlast set on the tick
// that ends playback. Registers are to be set over the APB port while idle;
// the block itself does not enforce this. Items are handled one at a time.
// A sample write, a start with an invalid mode or an idle tick goes straight
// to the result; a start divides out the clip length; a playing tick divides
// out the millisecond phase and, on a millisecond boundary, counts down and,
// unless playback ends there or jumps are off, tests the jump period by
// division; a random jump then divides out and scales the distance. All these
// divisions share one divider. The next input can transfer with the result.
// Reset stops playback, sets the duty to 127 and loads the register defaults;
// the sample store is not cleared and holds garbage until written.
// A stalled receiver holds the result in the output register; the next item
// is still taken and worked on, and its result waits for the register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcm_sample_player_with_random_jump #(
    parameter int SAMPLE_DEPTH = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pspr_pkg::PADDR_W-1:0]    paddr,
    input  logic [pspr_pkg::PDATA_W-1:0]    pwdata,
    output logic [pspr_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pspr_pkg::S_TDATA_W-1:0]  s_tdata,  // sample_address, sample_value, random_value
    input  logic [pspr_pkg::ACT_W-1:0]      s_tuser,  // action
    // Output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pspr_pkg::M_TDATA_W-1:0]  m_tdata,  // pwm_value
    output logic                            m_tuser,  // playing
    output logic                            m_tlast   // finished
);
    import pspr_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    pspr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pspr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pspr_datapath #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[src/pspr_checker.sv]
// ----------------------------------------------------------------------------
// PCM sample player port checker
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pspr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pspr_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);
    import pspr_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Items are worked on one at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // The ending tick reports idle duty and playback off
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tuser && (m_tdata == IDLE_DUTY))
        else $error("finished result not idle");

endmodule

bind pcm_sample_player_with_random_jump pspr_checker u_pspr_checker (.*);
